FILE: rtl/gesm_pkg.sv
// Shared types, constants and the key-code map of the gamepad event state mapper.
package gesm_pkg;

	// Q16 one and the stick and trigger full-scale factors
	localparam logic [16:0] Q_ONE = 17'd65536;
	localparam logic [14:0] STICK_FULL = 15'd32767;
	localparam logic [7:0] TRIG_FULL = 8'd255;

	// Configuration register indexes and reset values
	localparam logic [1:0] REG_DEADZONE = 2'd0;
	localparam logic [1:0] REG_TRIG_THR = 2'd1;
	localparam logic [1:0] REG_HAT_THR = 2'd2;
	localparam logic [16:0] DEADZONE_RST = 17'd9830;
	localparam logic [16:0] TRIG_THR_RST = 17'd3277;
	localparam logic [16:0] HAT_THR_RST = 17'd32768;

	// Motion axis numbers
	localparam logic [5:0] AX_LX = 6'd0;
	localparam logic [5:0] AX_LY = 6'd1;
	localparam logic [5:0] AX_RX = 6'd11;
	localparam logic [5:0] AX_RY = 6'd14;
	localparam logic [5:0] AX_HAT_X = 6'd15;
	localparam logic [5:0] AX_HAT_Y = 6'd16;
	localparam logic [5:0] AX_LTRIG = 6'd17;
	localparam logic [5:0] AX_RTRIG = 6'd18;
	localparam logic [5:0] AX_GAS = 6'd22;
	localparam logic [5:0] AX_BRAKE = 6'd23;

	// Key codes
	localparam logic [9:0] KEY_BACK = 10'd4;
	localparam logic [9:0] KEY_DPAD_UP = 10'd19;
	localparam logic [9:0] KEY_DPAD_DOWN = 10'd20;
	localparam logic [9:0] KEY_DPAD_LEFT = 10'd21;
	localparam logic [9:0] KEY_DPAD_RIGHT = 10'd22;
	localparam logic [9:0] KEY_A = 10'd96;
	localparam logic [9:0] KEY_B = 10'd97;
	localparam logic [9:0] KEY_X = 10'd99;
	localparam logic [9:0] KEY_Y = 10'd100;
	localparam logic [9:0] KEY_L1 = 10'd102;
	localparam logic [9:0] KEY_R1 = 10'd103;
	localparam logic [9:0] KEY_THUMBL = 10'd106;
	localparam logic [9:0] KEY_THUMBR = 10'd107;
	localparam logic [9:0] KEY_START = 10'd108;
	localparam logic [9:0] KEY_SELECT = 10'd109;
	localparam logic [9:0] KEY_MODE = 10'd110;

	// Button bits
	localparam logic [15:0] BTN_UP = 16'h0001;
	localparam logic [15:0] BTN_DOWN = 16'h0002;
	localparam logic [15:0] BTN_LEFT = 16'h0004;
	localparam logic [15:0] BTN_RIGHT = 16'h0008;
	localparam logic [15:0] BTN_START = 16'h0010;
	localparam logic [15:0] BTN_BACK = 16'h0020;
	localparam logic [15:0] BTN_THUMBL = 16'h0040;
	localparam logic [15:0] BTN_THUMBR = 16'h0080;
	localparam logic [15:0] BTN_LSHLD = 16'h0100;
	localparam logic [15:0] BTN_RSHLD = 16'h0200;
	localparam logic [15:0] BTN_GUIDE = 16'h0400;
	localparam logic [15:0] BTN_A = 16'h1000;
	localparam logic [15:0] BTN_B = 16'h2000;
	localparam logic [15:0] BTN_X = 16'h4000;
	localparam logic [15:0] BTN_Y = 16'h8000;
	localparam logic [15:0] BTN_NONE = 16'h0000;

	typedef enum logic [1:0] {
		OP_KEY   = 2'd0,
		OP_AXIS  = 2'd1,
		OP_TRIG  = 2'd2,
		OP_STICK = 2'd3
	} op_t;

	typedef struct packed {
		op_t                opcode;
		logic [9:0]         key_num;
		logic               key_down;
		logic [5:0]         axis_id;
		logic signed [19:0] axis_value;
		logic               right_side;
		logic [7:0]         raw_trigger;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
	} item_t;

	// stick order: left x, left y, right x, right y; trig order: left, right
	typedef struct packed {
		logic [3:0][15:0] stick;
		logic [1:0][7:0]  trig;
		logic [15:0]      buttons;
		logic [31:0]      count;
	} pad_state_t;

	typedef struct packed {
		logic [16:0] deadzone;
		logic [16:0] trig_thr;
		logic [16:0] hat_thr;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] stick;
		logic [7:0]         trig;
		logic               hat_neg;
		logic               hat_pos;
	} scale_res_t;

	function automatic logic [15:0] key_mask(input logic [9:0] code);
		logic [15:0] m;
		case (code)
			KEY_A:                m = BTN_A;
			KEY_B:                m = BTN_B;
			KEY_X:                m = BTN_X;
			KEY_Y:                m = BTN_Y;
			KEY_L1:               m = BTN_LSHLD;
			KEY_R1:               m = BTN_RSHLD;
			KEY_THUMBL:           m = BTN_THUMBL;
			KEY_THUMBR:           m = BTN_THUMBR;
			KEY_START:            m = BTN_START;
			KEY_SELECT, KEY_BACK: m = BTN_BACK;
			KEY_MODE:             m = BTN_GUIDE;
			KEY_DPAD_UP:          m = BTN_UP;
			KEY_DPAD_DOWN:        m = BTN_DOWN;
			KEY_DPAD_LEFT:        m = BTN_LEFT;
			KEY_DPAD_RIGHT:       m = BTN_RIGHT;
			default:              m = BTN_NONE;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/gesm_axis_scale.sv
// Axis conditioning: stick clamp, deadzone and scale, trigger scale, hat compare.
module gesm_axis_scale import gesm_pkg::*; (
	input  logic signed [19:0] value,
	input  logic               invert,
	input  cfg_t               cfg,
	output scale_res_t         res
);

	localparam logic signed [20:0] POS_ONE = 21'sd65536;
	localparam logic signed [20:0] NEG_ONE = -21'sd65536;

	logic signed [20:0] v_ext;
	logic signed [20:0] v_in;
	logic signed [17:0] v_clip;
	logic signed [17:0] v_neg;
	logic [16:0]        mag;
	logic [31:0]        stick_prod;
	logic [15:0]        stick_mag;
	logic signed [15:0] stick_val;
	logic [16:0]        trig_c;
	logic [24:0]        trig_prod;
	logic signed [20:0] hat_t;

	// Sign-extend and optionally invert (Y axes report up as positive)
	assign v_ext = {value[19], value};
	assign v_in = invert ? -v_ext : v_ext;

	// Clamp the stick reading to +-1.0 and take its magnitude
	always_comb begin
		if (v_in > POS_ONE) begin
			v_clip = POS_ONE[17:0];
		end else if (v_in < NEG_ONE) begin
			v_clip = NEG_ONE[17:0];
		end else begin
			v_clip = v_in[17:0];
		end
	end
	assign v_neg = -v_clip;
	assign mag = v_clip[17] ? v_neg[16:0] : v_clip[16:0];

	// Scale by full stick range, truncating, then apply deadzone and sign
	assign stick_prod = {15'd0, mag} * {17'd0, STICK_FULL};
	assign stick_mag = {1'b0, stick_prod[30:16]};
	always_comb begin
		if (mag < cfg.deadzone) begin
			stick_val = '0;
		end else if (v_clip[17]) begin
			stick_val = -$signed(stick_mag);
		end else begin
			stick_val = $signed(stick_mag);
		end
	end
	assign res.stick = stick_val;

	// Clamp the trigger reading to 0..1.0 and scale to 8 bits
	always_comb begin
		if (v_ext < 21'sd0) begin
			trig_c = '0;
		end else if (v_ext > POS_ONE) begin
			trig_c = Q_ONE;
		end else begin
			trig_c = v_ext[16:0];
		end
	end
	assign trig_prod = {8'd0, trig_c} * {17'd0, TRIG_FULL};
	assign res.trig = (trig_c < cfg.trig_thr) ? 8'd0 : trig_prod[23:16];

	// Hat direction decisions on the raw reading
	assign hat_t = $signed({4'd0, cfg.hat_thr});
	assign res.hat_neg = v_ext < -hat_t;
	assign res.hat_pos = v_ext > hat_t;

endmodule

FILE: rtl/gesm_update.sv
// Next-state logic: applies one item to the gamepad state.
module gesm_update import gesm_pkg::*; (
	input  item_t      item,
	input  pad_state_t cur,
	input  cfg_t       cfg,
	output pad_state_t nxt,
	output logic       applied
);

	scale_res_t  sc;
	logic        invert;
	logic [15:0] kmask;

	assign invert = (item.axis_id == AX_LY) || (item.axis_id == AX_RY);
	assign kmask = key_mask(item.key_num);

	gesm_axis_scale u_scale (
		.value  (item.axis_value),
		.invert (invert),
		.cfg    (cfg),
		.res    (sc)
	);

	// Decode the operation and build the state after the item
	always_comb begin
		nxt = cur;
		applied = 1'b1;
		case (item.opcode)
			OP_KEY: begin
				if (kmask == BTN_NONE) begin
					applied = 1'b0;
				end else begin
					nxt.count = cur.count + 32'd1;
					if (item.key_down) begin
						nxt.buttons = cur.buttons | kmask;
					end else begin
						nxt.buttons = cur.buttons & ~kmask;
					end
				end
			end
			OP_AXIS: begin
				nxt.count = cur.count + 32'd1;
				case (item.axis_id)
					AX_LX: nxt.stick[0] = sc.stick;
					AX_LY: nxt.stick[1] = sc.stick;
					AX_RX: nxt.stick[2] = sc.stick;
					AX_RY: nxt.stick[3] = sc.stick;
					AX_LTRIG, AX_BRAKE: nxt.trig[0] = sc.trig;
					AX_RTRIG, AX_GAS: nxt.trig[1] = sc.trig;
					AX_HAT_X: begin
						if (sc.hat_neg) begin
							nxt.buttons = (cur.buttons | BTN_LEFT) & ~BTN_RIGHT;
						end else if (sc.hat_pos) begin
							nxt.buttons = (cur.buttons | BTN_RIGHT) & ~BTN_LEFT;
						end else begin
							nxt.buttons = cur.buttons & ~(BTN_LEFT | BTN_RIGHT);
						end
					end
					AX_HAT_Y: begin
						if (sc.hat_neg) begin
							nxt.buttons = (cur.buttons | BTN_UP) & ~BTN_DOWN;
						end else if (sc.hat_pos) begin
							nxt.buttons = (cur.buttons | BTN_DOWN) & ~BTN_UP;
						end else begin
							nxt.buttons = cur.buttons & ~(BTN_UP | BTN_DOWN);
						end
					end
					default: begin
					end
				endcase
			end
			OP_TRIG: begin
				nxt.count = cur.count + 32'd1;
				nxt.trig[item.right_side] = item.raw_trigger;
			end
			OP_STICK: begin
				nxt.count = cur.count + 32'd1;
				nxt.stick[{item.right_side, 1'b0}] = item.raw_x;
				nxt.stick[{item.right_side, 1'b1}] = item.raw_y;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/gamepad_event_state_mapper.sv
// Path: input register, one pass of update logic, result register. An item moves on
// once the result register is free or draining; one item per cycle while m_tready is high.
// The next item sees the state written by the previous one at the same edge as its result.
// Reset (arst_n low, asynchronous): state and counter clear, thresholds take their defaults,
// both stages empty. No clearing pass; items are taken in the first cycle after reset.
module gamepad_event_state_mapper import gesm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// key_num[9:0], key_down[10], axis_id[16:11], axis_value[36:17], right_side[37],
	// raw_trigger[45:38], raw_x[61:46], raw_y[77:62], zero pad[79:78]
	input  logic [79:0]  s_tdata,
	// opcode[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// packet_count[31:0], button_bits[47:32], left_trig[55:48], right_trig[63:56],
	// left_stick_x[79:64], left_stick_y[95:80], right_stick_x[111:96], right_stick_y[127:112]
	output logic [127:0] m_tdata,
	// applied[0]
	output logic         m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [16:0]  cfg_data
);

	item_t      item_s1;
	logic       valid_s1;
	pad_state_t state_q;
	pad_state_t state_nxt;
	logic       applied_nxt;
	cfg_t       cfg_q;
	logic [127:0] out_data_q;
	logic       out_applied_q;
	logic       out_valid_q;
	logic       advance;
	item_t      in_item;

	// Unpack the incoming item
	always_comb begin
		in_item.opcode = op_t'(s_tuser);
		in_item.key_num = s_tdata[9:0];
		in_item.key_down = s_tdata[10];
		in_item.axis_id = s_tdata[16:11];
		in_item.axis_value = s_tdata[36:17];
		in_item.right_side = s_tdata[37];
		in_item.raw_trigger = s_tdata[45:38];
		in_item.raw_x = s_tdata[61:46];
		in_item.raw_y = s_tdata[77:62];
	end

	// Move the held item on whenever the result register is free or being drained
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item;
		end
	end

	// Configuration registers; an index beyond the list is dropped
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone <= DEADZONE_RST;
			cfg_q.trig_thr <= TRIG_THR_RST;
			cfg_q.hat_thr <= HAT_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEADZONE: cfg_q.deadzone <= cfg_data;
				REG_TRIG_THR: cfg_q.trig_thr <= cfg_data;
				REG_HAT_THR:  cfg_q.hat_thr <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	gesm_update u_update (
		.item    (item_s1),
		.cur     (state_q),
		.cfg     (cfg_q),
		.nxt     (state_nxt),
		.applied (applied_nxt)
	);

	// Gamepad state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= state_nxt;
			out_applied_q <= applied_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_applied_q;

`ifndef NO_ASSERTIONS
	// A result follows every item that leaves the input register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result missing after item advanced");

	// An applied item advances the counter by exactly one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && applied_nxt |=> state_q.count == $past(state_q.count) + 32'd1)
		else $error("counter did not advance by one");

	// An unmapped key leaves the whole state untouched
	a_unmapped_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !applied_nxt |=> state_q == $past(state_q))
		else $error("unmapped key changed state");

	// Reported state matches the stored state when a result is issued
	a_out_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tdata == state_q)
		else $error("result differs from stored state");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the gamepad event state mapper: directed, threshold, backpressure and random tests.
`timescale 1ns / 100ps

module tb_top;
	import gesm_pkg::*;

	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 6;
	localparam int IDLE_LIMIT = 3000;
	localparam logic [1:0] REG_SPARE = 2'd3;

	// one gamepad state as the block reports it
	typedef struct packed {
		logic [31:0]      count;
		logic [15:0]      buttons;
		logic [7:0]       ltrig;
		logic [7:0]       rtrig;
		logic [3:0][15:0] stick;
		logic             applied;
	} pad_view_t;

	localparam logic [9:0] MAPPED_KEYS [16] = '{KEY_A, KEY_B, KEY_X, KEY_Y, KEY_L1, KEY_R1,
		KEY_THUMBL, KEY_THUMBR, KEY_START, KEY_SELECT, KEY_BACK, KEY_MODE, KEY_DPAD_UP,
		KEY_DPAD_DOWN, KEY_DPAD_LEFT, KEY_DPAD_RIGHT};
	localparam logic [5:0] MAPPED_AXES [10] = '{AX_LX, AX_LY, AX_RX, AX_RY, AX_HAT_X,
		AX_HAT_Y, AX_LTRIG, AX_RTRIG, AX_GAS, AX_BRAKE};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [79:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [16:0]  cfg_data;

	// shadow state and thresholds of the block
	logic [15:0] pad_buttons;
	logic [7:0]  pad_trig [2];
	logic [15:0] pad_axes [4];
	logic [31:0] pad_count;
	logic [16:0] dz_cfg;
	logic [16:0] trig_thr_cfg;
	logic [16:0] hat_thr_cfg;

	pad_view_t pending_pads [$];
	int errors = 0;
	int idle_cycles = 0;
	int gap_odds = 0;
	int stall_odds = 0;
	bit sink_hold_req = 1'b0;

	gamepad_event_state_mapper u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic [15:0] button_of_key(input logic [9:0] code);
		case (code)
			KEY_A:                return BTN_A;
			KEY_B:                return BTN_B;
			KEY_X:                return BTN_X;
			KEY_Y:                return BTN_Y;
			KEY_L1:               return BTN_LSHLD;
			KEY_R1:               return BTN_RSHLD;
			KEY_THUMBL:           return BTN_THUMBL;
			KEY_THUMBR:           return BTN_THUMBR;
			KEY_START:            return BTN_START;
			KEY_SELECT, KEY_BACK: return BTN_BACK;
			KEY_MODE:             return BTN_GUIDE;
			KEY_DPAD_UP:          return BTN_UP;
			KEY_DPAD_DOWN:        return BTN_DOWN;
			KEY_DPAD_LEFT:        return BTN_LEFT;
			KEY_DPAD_RIGHT:       return BTN_RIGHT;
			default:              return BTN_NONE;
		endcase
	endfunction

	// clamp to +-1.0, zero inside the deadzone, scale toward zero
	function automatic logic [15:0] stick_level(input int v);
		int one;
		int c;
		int mag;
		int r;
		one = int'(Q_ONE);
		c = v;
		if (c > one) c = one;
		if (c < -one) c = -one;
		mag = (c < 0) ? -c : c;
		if (mag < int'(dz_cfg)) return 16'd0;
		r = (mag * int'(STICK_FULL)) >>> 16;
		return (c < 0) ? 16'(-r) : 16'(r);
	endfunction

	// clamp to 0..1.0, zero below the threshold, scale to 0..255
	function automatic logic [7:0] trig_level(input int v);
		int c;
		c = v;
		if (c < 0) c = 0;
		if (c > int'(Q_ONE)) c = int'(Q_ONE);
		if (c < int'(trig_thr_cfg)) return 8'd0;
		return 8'((c * int'(TRIG_FULL)) >>> 16);
	endfunction

	// press at most one bit of a direction pair
	function automatic void hat_press(input int v, input logic [15:0] neg_bit,
		input logic [15:0] pos_bit);
		int t;
		t = int'(hat_thr_cfg);
		if (v < -t)
			pad_buttons = (pad_buttons | neg_bit) & ~pos_bit;
		else if (v > t)
			pad_buttons = (pad_buttons | pos_bit) & ~neg_bit;
		else
			pad_buttons = pad_buttons & ~(neg_bit | pos_bit);
	endfunction

	// apply one item to the shadow state and return the state to be reported
	function automatic pad_view_t advance_pad(input item_t it);
		pad_view_t pv;
		logic [15:0] m;
		int v;
		pv.applied = 1'b1;
		v = $signed(it.axis_value);
		case (it.opcode)
			OP_KEY: begin
				m = button_of_key(it.key_num);
				if (m == BTN_NONE) begin
					pv.applied = 1'b0;
				end else begin
					pad_count++;
					pad_buttons = it.key_down ? (pad_buttons | m) : (pad_buttons & ~m);
				end
			end
			OP_AXIS: begin
				pad_count++;
				case (it.axis_id)
					AX_LX:              pad_axes[0] = stick_level(v);
					AX_LY:              pad_axes[1] = stick_level(-v);
					AX_RX:              pad_axes[2] = stick_level(v);
					AX_RY:              pad_axes[3] = stick_level(-v);
					AX_LTRIG, AX_BRAKE: pad_trig[0] = trig_level(v);
					AX_RTRIG, AX_GAS:   pad_trig[1] = trig_level(v);
					AX_HAT_X:           hat_press(v, BTN_LEFT, BTN_RIGHT);
					AX_HAT_Y:           hat_press(v, BTN_UP, BTN_DOWN);
					default:            ;
				endcase
			end
			OP_TRIG: begin
				pad_count++;
				pad_trig[it.right_side] = it.raw_trigger;
			end
			default: begin
				pad_count++;
				pad_axes[{it.right_side, 1'b0}] = it.raw_x;
				pad_axes[{it.right_side, 1'b1}] = it.raw_y;
			end
		endcase
		pv.count = pad_count;
		pv.buttons = pad_buttons;
		pv.ltrig = pad_trig[0];
		pv.rtrig = pad_trig[1];
		for (int i = 0; i < 4; i++)
			pv.stick[i] = pad_axes[i];
		return pv;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// compare each result with the oldest expected state
	always @(posedge clk) begin : result_check
		pad_view_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pads.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_tdata);
				errors++;
			end else begin
				want = pending_pads.pop_front();
				check_field("packet_count", want.count, m_tdata[31:0]);
				check_field("button_bits", 32'(want.buttons), 32'(m_tdata[47:32]));
				check_field("left_trig", 32'(want.ltrig), 32'(m_tdata[55:48]));
				check_field("right_trig", 32'(want.rtrig), 32'(m_tdata[63:56]));
				check_field("left_stick_x", 32'(want.stick[0]), 32'(m_tdata[79:64]));
				check_field("left_stick_y", 32'(want.stick[1]), 32'(m_tdata[95:80]));
				check_field("right_stick_x", 32'(want.stick[2]), 32'(m_tdata[111:96]));
				check_field("right_stick_y", 32'(want.stick[3]), 32'(m_tdata[127:112]));
				check_field("applied", 32'(want.applied), 32'(m_tuser));
			end
		end
	end

	// end the run when no item moves for too long
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// result side: random stall bursts, or one long hold on request
	initial begin : sink_pace
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				sink_hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- driving

	// offer one item, leave valid high afterwards
	task automatic push_item(input item_t it);
		if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.opcode;
		s_tdata <= {2'b00, it.raw_y, it.raw_x, it.raw_trigger, it.right_side, it.axis_value,
			it.axis_id, it.key_down, it.key_num};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_pads = {pending_pads, advance_pad(it)};
	endtask

	// stop offering and wait until every expected state has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_pads.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DEADZONE: dz_cfg = val;
			REG_TRIG_THR: trig_thr_cfg = val;
			REG_HAT_THR:  hat_thr_cfg = val;
			default:      ;
		endcase
	endtask

	// write all thresholds and the unused index, block idle
	task automatic program_regs(input logic [16:0] dz, input logic [16:0] tt,
		input logic [16:0] ht);
		write_reg(REG_DEADZONE, dz);
		write_reg(REG_TRIG_THR, tt);
		write_reg(REG_SPARE, 17'($urandom));
		write_reg(REG_HAT_THR, ht);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------- items

	// every field random; the builders below override what matters
	function automatic item_t blank_item();
		item_t it;
		it.opcode = op_t'($urandom_range(0, 3));
		it.key_num = 10'($urandom);
		it.key_down = 1'($urandom);
		it.axis_id = 6'($urandom);
		it.axis_value = 20'($urandom);
		it.right_side = 1'($urandom);
		it.raw_trigger = 8'($urandom);
		it.raw_x = 16'($urandom);
		it.raw_y = 16'($urandom);
		return it;
	endfunction

	function automatic item_t key_ev(input logic [9:0] code, input logic down);
		item_t it;
		it = blank_item();
		it.opcode = OP_KEY;
		it.key_num = code;
		it.key_down = down;
		return it;
	endfunction

	function automatic item_t axis_ev(input logic [5:0] id, input int val);
		item_t it;
		it = blank_item();
		it.opcode = OP_AXIS;
		it.axis_id = id;
		it.axis_value = 20'(val);
		return it;
	endfunction

	function automatic item_t trig_ev(input logic side, input logic [7:0] lvl);
		item_t it;
		it = blank_item();
		it.opcode = OP_TRIG;
		it.right_side = side;
		it.raw_trigger = lvl;
		return it;
	endfunction

	function automatic item_t stick_ev(input logic side, input logic [15:0] x,
		input logic [15:0] y);
		item_t it;
		it = blank_item();
		it.opcode = OP_STICK;
		it.right_side = side;
		it.raw_x = x;
		it.raw_y = y;
		return it;
	endfunction

	// axis reading: full range, unit range, field extremes, or just around a threshold
	function automatic int pick_axis_value();
		int base;
		int v;
		case ($urandom_range(0, 5))
			0: v = $signed(20'($urandom));
			1, 2: v = $urandom_range(0, 131072) - 65536;
			3: v = ($urandom_range(0, 1) != 0) ? 524287 : -524288;
			default: begin
				case ($urandom_range(0, 2))
					0: base = int'(dz_cfg);
					1: base = int'(trig_thr_cfg);
					default: base = int'(hat_thr_cfg);
				endcase
				v = base + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1) != 0) v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic item_t random_item();
		int pick;
		item_t it;
		pick = $urandom_range(1, 100);
		it = blank_item();
		if (pick <= 35) begin
			it.opcode = OP_KEY;
			if ($urandom_range(0, 3) != 0) it.key_num = MAPPED_KEYS[$urandom_range(0, 15)];
		end else if (pick <= 75) begin
			it.opcode = OP_AXIS;
			if ($urandom_range(0, 4) != 0) it.axis_id = MAPPED_AXES[$urandom_range(0, 9)];
			it.axis_value = 20'(pick_axis_value());
		end else if (pick <= 87) begin
			it.opcode = OP_TRIG;
		end else begin
			it.opcode = OP_STICK;
		end
		return it;
	endfunction

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			push_item(random_item());
	endtask

	// ---------------------------------------------------------------- tests

	// reset thresholds: field extremes, each operation, each special case
	task automatic test_directed_events();
		gap_odds = 15;
		stall_odds = 15;
		push_item(key_ev(KEY_A, 1'b1));
		push_item(key_ev(KEY_BACK, 1'b1));
		push_item(key_ev(KEY_SELECT, 1'b0));
		push_item(key_ev(KEY_DPAD_UP, 1'b1));
		// unmapped keys change nothing
		push_item(key_ev(10'd0, 1'b1));
		push_item(key_ev(10'd1023, 1'b1));
		push_item(axis_ev(AX_LX, 524287));
		push_item(axis_ev(AX_LY, -524288));
		push_item(axis_ev(AX_RX, int'(DEADZONE_RST) - 1));
		push_item(axis_ev(AX_RY, int'(DEADZONE_RST)));
		push_item(axis_ev(AX_LTRIG, int'(TRIG_THR_RST) - 1));
		push_item(axis_ev(AX_GAS, 65536));
		push_item(axis_ev(AX_RTRIG, -5));
		push_item(axis_ev(AX_BRAKE, 70000));
		// hat left just beyond the threshold, then exactly on it clears the pair
		push_item(axis_ev(AX_HAT_X, -int'(HAT_THR_RST) - 1));
		push_item(axis_ev(AX_HAT_X, int'(HAT_THR_RST)));
		push_item(axis_ev(AX_HAT_Y, 40000));
		// unmapped axis advances the counter only
		push_item(axis_ev(6'd63, 12345));
		// direct writes are stored raw
		push_item(trig_ev(1'b0, 8'd255));
		push_item(trig_ev(1'b1, 8'd0));
		push_item(stick_ev(1'b0, 16'h8000, 16'h7fff));
		push_item(stick_ev(1'b1, 16'h7fff, 16'h8000));
		drain_results();
	endtask

	// random items under zero, unit, oversize and random thresholds
	task automatic test_threshold_sweep();
		logic [16:0] dz_set [6];
		logic [16:0] tt_set [6];
		logic [16:0] ht_set [6];
		dz_set = '{17'd0, 17'd65536, 17'h1ffff, 17'($urandom_range(0, 65536)),
			17'($urandom), DEADZONE_RST};
		tt_set = '{17'd0, 17'd65536, 17'h1ffff, 17'($urandom_range(0, 65536)),
			17'($urandom), TRIG_THR_RST};
		ht_set = '{17'd0, 17'd65536, 17'h1ffff, 17'($urandom_range(0, 65536)),
			17'($urandom), HAT_THR_RST};
		for (int s = 0; s < 6; s++) begin
			program_regs(dz_set[s], tt_set[s], ht_set[s]);
			gap_odds = (s % 2 == 0) ? 20 : 0;
			stall_odds = (s % 3 == 0) ? 0 : 25;
			push_random(50);
			drain_results();
		end
	endtask

	// receiver holds off long while items keep coming, so the block stalls its input
	task automatic test_output_backpressure();
		gap_odds = 0;
		stall_odds = 0;
		sink_hold_req = 1'b1;
		push_random(40);
		drain_results();
	endtask

	// long random run, idling in stretches, none at the end
	task automatic test_random_soak();
		gap_odds = 20;
		stall_odds = 20;
		push_random(160);
		gap_odds = 0;
		stall_odds = 0;
		push_random(160);
		gap_odds = 35;
		stall_odds = 35;
		push_random(160);
		gap_odds = 0;
		stall_odds = 0;
		push_random(160);
		drain_results();
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_KEY;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DEADZONE;
		cfg_data <= '0;
		pad_buttons = BTN_NONE;
		pad_trig = '{8'd0, 8'd0};
		pad_axes = '{16'd0, 16'd0, 16'd0, 16'd0};
		pad_count = '0;
		dz_cfg = DEADZONE_RST;
		trig_thr_cfg = TRIG_THR_RST;
		hat_thr_cfg = HAT_THR_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_events();
		test_threshold_sweep();
		test_output_backpressure();
		test_random_soak();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: gamepad_event_state_mapper.f
rtl/gesm_pkg.sv
rtl/gesm_axis_scale.sv
rtl/gesm_update.sv
rtl/gamepad_event_state_mapper.sv
tb/tb_top.sv
